// ===== rtl/core/upt_pkg.sv =====
`timescale 1ns / 1ps
package upt_pkg;

    // Queue between the classifier and the result sequencer (bundles).
    localparam int QUEUE_DEPTH = 2;

    // Most results one input byte can cause.
    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    // Configuration register indexes
    localparam int         CFG_INDEX_W     = 1;
    localparam logic [0:0] CFG_URI_MODE    = 1'b0;
    localparam logic [0:0] CFG_ACCEPT_LOWER = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // Special characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [3:0] HEX_TEN    = 4'hA;

    typedef enum logic [3:0] {
        PH_PATH  = 4'b0001,
        PH_KEY   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_START = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_t;

    typedef struct packed {
        logic uri_mode;
        logic accept_lowercase;
    } cfg_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic [1:0] kind;
        logic       field_end;
        logic       pair_end;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]              count;
        result_t [MAX_RESULTS-1:0]       items;
    } bundle_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
        logic       lower;
    } hex_t;

    function automatic hex_t hex_of(input logic [7:0] c, input logic lc);
        hex_t h;
        h = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.ok  = 1'b1;
            h.val = c[3:0];
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end else if (lc && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            h.ok    = 1'b1;
            h.val   = c[3:0] + 4'd9;
            h.lower = 1'b1;
        end
        return h;
    endfunction

    // Character that spells a held hex digit back out.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] ch;
        if (d < HEX_TEN) begin
            ch = CH_ZERO + {4'h0, d};
        end else begin
            ch = (lower ? CH_LOWER_A : CH_UPPER_A) + {4'h0, d - HEX_TEN};
        end
        return ch;
    endfunction

    function automatic logic [1:0] phase_kind(input phase_t ph);
        logic [1:0] k;
        unique case (ph)
            PH_PATH:  k = KIND_PATH;
            PH_VALUE: k = KIND_VALUE;
            default:  k = KIND_KEY;
        endcase
        return k;
    endfunction

    function automatic result_t make_result(input logic has, input logic [7:0] b,
                                            input logic [1:0] k, input logic fe,
                                            input logic pe);
        result_t r;
        r.has_byte  = has;
        r.data      = b;
        r.kind      = k;
        r.field_end = fe;
        r.pair_end  = pe;
        return r;
    endfunction

endpackage

// ===== rtl/core/upt_front.sv =====
`timescale 1ns / 1ps
module upt_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  upt_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             last,
    input  logic             q_full,
    output logic             push,
    output upt_pkg::bundle_t push_bundle
);

    upt_pkg::phase_t phase_reg, phase_next;
    upt_pkg::esc_t   esc_reg, esc_next;
    logic [3:0]      held_digit_reg, held_digit_next;
    logic            held_lower_reg, held_lower_next;
    logic            seg_reg, seg_next;

    logic [upt_pkg::COUNT_W-1:0] n;
    upt_pkg::hex_t               hx;
    logic                        handled;
    logic                        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (n != '0);

    always_comb begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_digit_next = held_digit_reg;
        held_lower_next = held_lower_reg;
        seg_next        = seg_reg;
        n               = '0;
        push_bundle     = '0;
        handled         = 1'b0;
        hx              = upt_pkg::hex_of(in_byte, cfg.accept_lowercase);

        // Resolve the phase on the first byte of a string.
        if (phase_next == upt_pkg::PH_START) begin
            phase_next = cfg.uri_mode ? upt_pkg::PH_PATH : upt_pkg::PH_KEY;
            seg_next   = 1'b0;
            esc_next   = upt_pkg::ESC_NONE;
        end

        if (phase_next == upt_pkg::PH_PATH) begin
            if (in_byte == upt_pkg::CH_QMARK) begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_PATH, 1'b1, 1'b0);
                n          = n + 1'b1;
                phase_next = upt_pkg::PH_KEY;
                seg_next   = 1'b0;
            end else begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b1, in_byte, upt_pkg::KIND_PATH, 1'b0, 1'b0);
                n = n + 1'b1;
            end
            handled = 1'b1;
        end else if (esc_next != upt_pkg::ESC_NONE && hx.ok) begin
            if (esc_next == upt_pkg::ESC_PCT) begin
                held_digit_next = hx.val;
                held_lower_next = hx.lower;
                esc_next        = upt_pkg::ESC_DIGIT;
            end else begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b1, {held_digit_next, hx.val},
                                         upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
                n        = n + 1'b1;
                esc_next = upt_pkg::ESC_NONE;
            end
            handled = 1'b1;
        end else if (esc_next != upt_pkg::ESC_NONE) begin
            // bad escape: spill what was held
            push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                upt_pkg::make_result(1'b1, upt_pkg::CH_PERCENT,
                                     upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
            n = n + 1'b1;
            if (esc_next == upt_pkg::ESC_DIGIT) begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b1,
                                         upt_pkg::digit_char(held_digit_next, held_lower_next),
                                         upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
                n = n + 1'b1;
            end
            esc_next = upt_pkg::ESC_NONE;
        end

        if (!handled) begin
            if (in_byte == upt_pkg::CH_PERCENT) begin
                esc_next = upt_pkg::ESC_PCT;
                seg_next = 1'b1;
            end else if (in_byte == upt_pkg::CH_AMP) begin
                if (phase_next == upt_pkg::PH_KEY) begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_KEY, 1'b1, 1'b1);
                end else begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_VALUE, 1'b0, 1'b1);
                end
                n          = n + 1'b1;
                phase_next = upt_pkg::PH_KEY;
                seg_next   = 1'b0;
            end else if (in_byte == upt_pkg::CH_EQUAL && phase_next == upt_pkg::PH_KEY) begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_KEY, 1'b1, 1'b0);
                n          = n + 1'b1;
                phase_next = upt_pkg::PH_VALUE;
                seg_next   = 1'b1;
            end else begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b1, in_byte,
                                         upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
                n        = n + 1'b1;
                seg_next = 1'b1;
            end
        end

        if (last) begin
            if (phase_next == upt_pkg::PH_PATH) begin
                push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                    upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_PATH, 1'b1, 1'b0);
                n = n + 1'b1;
            end else begin
                // unfinished escape goes out literally
                if (esc_next != upt_pkg::ESC_NONE) begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b1, upt_pkg::CH_PERCENT,
                                             upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
                    n = n + 1'b1;
                end
                if (esc_next == upt_pkg::ESC_DIGIT) begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b1,
                                             upt_pkg::digit_char(held_digit_next,
                                                                 held_lower_next),
                                             upt_pkg::phase_kind(phase_next), 1'b0, 1'b0);
                    n = n + 1'b1;
                end
                if (phase_next == upt_pkg::PH_VALUE) begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_VALUE, 1'b0, 1'b1);
                    n = n + 1'b1;
                end else if (seg_next) begin
                    push_bundle.items[n[upt_pkg::SLOT_W-1:0]] =
                        upt_pkg::make_result(1'b0, 8'h00, upt_pkg::KIND_KEY, 1'b1, 1'b1);
                    n = n + 1'b1;
                end
            end
            phase_next      = upt_pkg::PH_START;
            esc_next        = upt_pkg::ESC_NONE;
            held_digit_next = 4'h0;
            held_lower_next = 1'b0;
            seg_next        = 1'b0;
        end

        push_bundle.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= upt_pkg::PH_START;
            esc_reg        <= upt_pkg::ESC_NONE;
            held_digit_reg <= 4'h0;
            held_lower_reg <= 1'b0;
            seg_reg        <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_digit_reg <= held_digit_next;
            held_lower_reg <= held_lower_next;
            seg_reg        <= seg_next;
        end
    end

    // Path phase never holds a pending escape.
    a_path_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == upt_pkg::PH_PATH |-> esc_reg == upt_pkg::ESC_NONE)
        else $error("escape pending in path phase");

    // Last byte always returns the tokenizer to its start state.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == upt_pkg::PH_START && esc_reg == upt_pkg::ESC_NONE)
        else $error("string end did not restart");

endmodule

// ===== rtl/core/upt_queue.sv =====
`timescale 1ns / 1ps
module upt_queue
#(
    parameter int DEPTH = upt_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  upt_pkg::bundle_t push_bundle,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output upt_pkg::bundle_t head_bundle
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upt_pkg::bundle_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full        = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid  = (cnt_reg != '0);
    assign head_bundle = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/upt_back.sv =====
`timescale 1ns / 1ps
module upt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  upt_pkg::bundle_t head_bundle,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output upt_pkg::result_t out_result,
    output logic             out_run_last
);

    logic [upt_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    upt_pkg::result_t           res_reg;
    logic                       run_last_reg;
    logic                       load;
    logic                       at_end;

    assign load   = head_valid && (!valid_reg || out_ready);
    assign at_end = ({1'b0, idx_reg} == head_bundle.count - 1'b1);
    assign pop    = load && at_end;

    assign out_valid    = valid_reg;
    assign out_result   = res_reg;
    assign out_run_last = run_last_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg      <= head_bundle.items[idx_reg];
            run_last_reg <= at_end;
        end
    end

    // Slot index only walks inside a bundle that is present.
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == '0)
        else $error("slot index left over with empty queue");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> head_bundle.count != '0 && {1'b0, idx_reg} < head_bundle.count)
        else $error("slot index beyond bundle");

endmodule

// ===== rtl/core/urlencoded_param_tokenizer.sv =====
`timescale 1ns / 1ps
// URL query / form body tokenizer with percent decoding.
// Input channel (in_valid/in_ready): one raw byte per request, last marks the
// final byte of a string. Output channel (out_valid/out_ready): one result per
// request - a decoded byte or an end marker, tagged path/key/value, with
// run_last on the final result caused by an input byte. Bytes that cause no
// result (a '%' or first escape digit) produce no output request.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 uri_mode,
// index 1 accept_lowercase; write only while the block is idle.
// A byte's results are written into the bundle queue, then the first is
// registered in the output register. Throughput: one byte per cycle while
// each byte yields at most one result and the receiver stays ready; a byte
// yielding several results holds the result sequencer until all are out, and
// the bundle queue (QUEUE_DEPTH bytes) soaks that up before in_ready drops.
// Reset clears the control state: tokenizer waits for a string start, config is 0.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls, with nothing dropped.
module urlencoded_param_tokenizer
#(
    parameter int QUEUE_DEPTH = upt_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [upt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            has_byte,
    output logic [7:0]                      out_byte,
    output logic [1:0]                      kind,
    output logic                            field_end,
    output logic                            pair_end,
    output logic                            run_last
);

    upt_pkg::cfg_t    cfg_reg;
    logic             q_full;
    logic             push;
    upt_pkg::bundle_t push_bundle;
    logic             pop;
    logic             head_valid;
    upt_pkg::bundle_t head_bundle;
    upt_pkg::result_t out_result;

    // Config registers; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                upt_pkg::CFG_URI_MODE:     cfg_reg.uri_mode         <= cfg_data;
                upt_pkg::CFG_ACCEPT_LOWER: cfg_reg.accept_lowercase <= cfg_data;
                default:                   cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Front: classify each byte, build its bundle of results.
    upt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .last        (last),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // Bundle queue decouples byte intake from result delivery.
    upt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_bundle (head_bundle)
    );

    // Back: hand out one result per cycle through the output register while the receiver is ready.
    upt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_bundle  (head_bundle),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_result   (out_result),
        .out_run_last (run_last)
    );

    assign has_byte  = out_result.has_byte;
    assign out_byte  = out_result.data;
    assign kind      = out_result.kind;
    assign field_end = out_result.field_end;
    assign pair_end  = out_result.pair_end;

endmodule

// ===== bench/urlencoded_param_tokenizer_tb.sv =====
`timescale 1ns / 1ps
module urlencoded_param_tokenizer_tb;
    import upt_pkg::*;

    // Cycles to let the pipeline empty once nothing is expected. This covers
    // bytes that make no result, such as '%' or a first escape digit.
    localparam int SETTLE_CYCLES = 8;
    // Minimum random bytes per configuration phase (four phases).
    localparam int PHASE_ITEMS   = 62;

    // One expected output request: the result fields plus the run_last flag.
    typedef struct packed {
        result_t res;
        logic    run_last;
    } token_t;

    // Tracks the tokenizer state and keeps the tokens still owed by the DUT.
    class token_checker;
        token_t     pending_tokens[$];
        token_t     batch[$];
        int         errors;
        logic       uri_mode;
        logic       lower_ok;
        phase_t     phase;
        esc_t       esc;
        logic [3:0] held_digit;
        logic       held_lower;
        logic       seg_open;

        function new();
            uri_mode = 1'b0;
            lower_ok = 1'b0;
            errors   = 0;
            restart();
        endfunction

        // State at reset and after every string end.
        function void restart();
            phase      = PH_START;
            esc        = ESC_NONE;
            held_digit = 4'h0;
            held_lower = 1'b0;
            seg_open   = 1'b0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
            if (idx == CFG_URI_MODE)
                uri_mode = val;
            else if (idx == CFG_ACCEPT_LOWER)
                lower_ok = val;
        endfunction

        function logic [1:0] kind_now();
            if (phase == PH_PATH)
                return KIND_PATH;
            else if (phase == PH_VALUE)
                return KIND_VALUE;
            return KIND_KEY;
        endfunction

        function void add(input logic has, input logic [7:0] b, input logic [1:0] k,
                          input logic fe, input logic pe);
            token_t t;
            t.res.has_byte  = has;
            t.res.data      = b;
            t.res.kind      = k;
            t.res.field_end = fe;
            t.res.pair_end  = pe;
            t.run_last      = 1'b0;
            batch.push_back(t);
        endfunction

        // Hex digit test; lowercase only when enabled, nothing at 128 and up.
        function bit hex_digit(input logic [7:0] c, output logic [3:0] v,
                               output logic lc);
            logic [7:0] d;
            lc = 1'b0;
            v  = 4'h0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
                d = c - CH_UPPER_A + {4'h0, HEX_TEN};
            end else if (lower_ok && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
                d  = c - CH_LOWER_A + {4'h0, HEX_TEN};
                lc = 1'b1;
            end else begin
                return 1'b0;
            end
            v = d[3:0];
            return 1'b1;
        endfunction

        // Pending '%' and held digit come out literally, in original case.
        function void flush_escape();
            logic [7:0] ch;
            if (esc != ESC_NONE)
                add(1'b1, CH_PERCENT, kind_now(), 1'b0, 1'b0);
            if (esc == ESC_DIGIT) begin
                if (held_digit < HEX_TEN)
                    ch = CH_ZERO + {4'h0, held_digit};
                else
                    ch = (held_lower ? CH_LOWER_A : CH_UPPER_A)
                         + {4'h0, held_digit} - {4'h0, HEX_TEN};
                add(1'b1, ch, kind_now(), 1'b0, 1'b0);
            end
            esc = ESC_NONE;
        endfunction

        // Called for each accepted input request.
        function void note_byte(input logic [7:0] c, input logic is_last);
            bit         handled;
            logic [3:0] v;
            logic       lc;
            token_t     t;
            batch.delete();
            handled = 0;
            if (phase == PH_START) begin
                if (uri_mode)
                    phase = PH_PATH;
                else
                    phase = PH_KEY;
                seg_open = 1'b0;
                esc      = ESC_NONE;
            end

            if (phase == PH_PATH) begin
                if (c == CH_QMARK) begin
                    add(1'b0, 8'h00, KIND_PATH, 1'b1, 1'b0);
                    phase    = PH_KEY;
                    seg_open = 1'b0;
                end else begin
                    add(1'b1, c, KIND_PATH, 1'b0, 1'b0);
                end
                handled = 1;
            end else if (esc == ESC_PCT) begin
                if (hex_digit(c, v, lc)) begin
                    held_digit = v;
                    held_lower = lc;
                    esc        = ESC_DIGIT;
                    handled    = 1;
                end else begin
                    flush_escape();
                end
            end else if (esc == ESC_DIGIT) begin
                if (hex_digit(c, v, lc)) begin
                    add(1'b1, {held_digit, v}, kind_now(), 1'b0, 1'b0);
                    esc     = ESC_NONE;
                    handled = 1;
                end else begin
                    flush_escape();
                end
            end

            if (!handled) begin
                if (c == CH_PERCENT) begin
                    esc      = ESC_PCT;
                    seg_open = 1'b1;
                end else if (c == CH_AMP) begin
                    if (phase == PH_KEY)
                        add(1'b0, 8'h00, KIND_KEY, 1'b1, 1'b1);
                    else
                        add(1'b0, 8'h00, KIND_VALUE, 1'b0, 1'b1);
                    phase    = PH_KEY;
                    seg_open = 1'b0;
                end else if (c == CH_EQUAL && phase == PH_KEY) begin
                    add(1'b0, 8'h00, KIND_KEY, 1'b1, 1'b0);
                    phase    = PH_VALUE;
                    seg_open = 1'b1;
                end else begin
                    add(1'b1, c, kind_now(), 1'b0, 1'b0);
                    seg_open = 1'b1;
                end
            end

            if (is_last) begin
                if (phase == PH_PATH) begin
                    add(1'b0, 8'h00, KIND_PATH, 1'b1, 1'b0);
                end else begin
                    flush_escape();
                    if (phase == PH_VALUE)
                        add(1'b0, 8'h00, KIND_VALUE, 1'b0, 1'b1);
                    else if (seg_open)
                        add(1'b0, 8'h00, KIND_KEY, 1'b1, 1'b1);
                end
                restart();
            end

            foreach (batch[i]) begin
                t          = batch[i];
                t.run_last = (i == batch.size() - 1);
                pending_tokens.push_back(t);
            end
        endfunction

        function void compare(input string name, input int exp_val, input int got);
            if (exp_val != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
                errors++;
            end
        endfunction

        // Called for each accepted output request.
        function void check_token(input logic has, input logic [7:0] b,
                                  input logic [1:0] k, input logic fe,
                                  input logic pe, input logic rl);
            token_t t;
            if (pending_tokens.size() == 0) begin
                $error("unexpected result: has_byte=%0b out_byte=0x%0h kind=%0d",
                       has, b, k);
                errors++;
                return;
            end
            t = pending_tokens.pop_front();
            compare("has_byte", t.res.has_byte, has);
            compare("out_byte", t.res.data, b);
            compare("kind", t.res.kind, k);
            compare("field_end", t.res.field_end, fe);
            compare("pair_end", t.res.pair_end, pe);
            compare("run_last", t.run_last, rl);
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic                   cfg_data  = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte   = 8'h00;
    logic                   last      = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   has_byte;
    logic [7:0]             out_byte;
    logic [1:0]             kind;
    logic                   field_end;
    logic                   pair_end;
    logic                   run_last;

    token_checker sb = new();

    // Per-string switches: when set, that side runs without idle cycles.
    bit         tx_eager = 1'b0;
    bit         rx_eager = 1'b0;
    logic [7:0] str_q[$];
    int         items_sent = 0;

    urlencoded_param_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_byte  (has_byte),
        .out_byte  (out_byte),
        .kind      (kind),
        .field_end (field_end),
        .pair_end  (pair_end),
        .run_last  (run_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Register write; only issued while the tokenizer is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One input request. Valid drops only when a gap is drawn, so a
    // back-to-back request never sees valid lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= is_last;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b, is_last);
        items_sent++;
    endtask

    // Sender holds off until every expected token is back, then lets the
    // pipeline settle (covers bytes that produced nothing).
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sends str_q as one string; pause_at >= 0 drains mid-string first.
    task automatic send_string(input int pause_at);
        tx_eager = ($urandom_range(0, 3) == 0);
        rx_eager = ($urandom_range(0, 3) == 0);
        foreach (str_q[i]) begin
            if (i == pause_at)
                hold_until_drained();
            send_byte(str_q[i], i == str_q.size() - 1);
        end
    endtask

    // Hex digit in either case; lowercase ones also probe the rejection path.
    function automatic logic [7:0] hex_char();
        logic [3:0] d;
        d = 4'($urandom_range(0, 15));
        if (d < HEX_TEN)
            return CH_ZERO + {4'h0, d};
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A)
               + {4'h0, d} - {4'h0, HEX_TEN};
    endfunction

    // Mostly well-formed query strings with random content, plus noise.
    function automatic void compose_string(input logic uri);
        int n_tokens;
        int pick;
        if (uri == 1'b0 || $urandom_range(0, 9) >= 7)
            str_q.delete();
        else
        begin
            str_q.delete();
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 1))
                    str_q.push_back(8'($urandom_range(0, 255)));
                else
                    str_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
            end
            str_q.push_back(CH_QMARK);
        end
        n_tokens = $urandom_range(1, 8);
        repeat (n_tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                str_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
            end else if (pick < 48) begin
                str_q.push_back(CH_PERCENT);
                str_q.push_back(hex_char());
                str_q.push_back(hex_char());
            end else if (pick < 60) begin
                str_q.push_back(CH_AMP);
            end else if (pick < 70) begin
                str_q.push_back(CH_EQUAL);
            end else if (pick < 74) begin
                str_q.push_back(CH_QMARK);
            end else if (pick < 84) begin
                // broken escape: percent, maybe one digit, then anything
                str_q.push_back(CH_PERCENT);
                if ($urandom_range(0, 1))
                    str_q.push_back(hex_char());
                str_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                str_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Output side: random stall before each result, sampled at rising edge.
    initial
    begin
        int stall;
        forever begin
            stall = rx_eager ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_token(has_byte, out_byte, kind, field_end, pair_end, run_last);
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic uri_set[4];
        logic lower_set[4];
        int   phase_start;
        int   pause_at;
        uri_set   = '{1'b1, 1'b0, 1'b1, 1'b0};
        lower_set = '{1'b1, 1'b0, 1'b0, 1'b1};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, URI mode, uppercase hex only:
        // percent and 0xFF in path, path end, bad escape, lowercase rejected,
        // second '=', "%30" decodes to '0', empty pair, 0x00 key byte,
        // escape cut by string end.
        write_reg(CFG_URI_MODE, 1'b1);
        write_reg(CFG_ACCEPT_LOWER, 1'b0);
        str_q = '{CH_PERCENT, 8'hFF, CH_QMARK, CH_PERCENT, "4", "g", CH_EQUAL,
                  CH_PERCENT, "a", CH_EQUAL, CH_PERCENT, "3", "0", CH_AMP, CH_AMP,
                  8'h00, CH_PERCENT, "8"};
        send_string(-1);
        hold_until_drained();

        // Parameters only, lowercase on: 0x80 after percent is not hex,
        // "%fF" on the final byte decodes, then a string of a lone '&'.
        write_reg(CFG_URI_MODE, 1'b0);
        write_reg(CFG_ACCEPT_LOWER, 1'b1);
        str_q = '{CH_PERCENT, 8'h80, CH_EQUAL, CH_PERCENT, "f", "F"};
        send_string(-1);
        str_q = '{CH_AMP};
        send_string(-1);

        // Random phases over all four register settings.
        foreach (uri_set[p]) begin
            hold_until_drained();
            write_reg(CFG_URI_MODE, uri_set[p]);
            write_reg(CFG_ACCEPT_LOWER, lower_set[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                compose_string(uri_set[p]);
                // mid-string hold-offs early in the second phase
                pause_at = -1;
                if (p == 1 && items_sent - phase_start < 10 && str_q.size() > 2)
                    pause_at = str_q.size() / 2;
                send_string(pause_at);
            end
        end

        hold_until_drained();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== urlencoded_param_tokenizer.f =====
rtl/core/upt_pkg.sv
rtl/core/upt_front.sv
rtl/core/upt_queue.sv
rtl/core/upt_back.sv
rtl/core/urlencoded_param_tokenizer.sv
bench/urlencoded_param_tokenizer_tb.sv
